### rtl/lprs_pkg.sv
// lprs_pkg: widths, register indexes, reset values and shared types
// for the lidar point run segmenter; used by every module in rtl/
package lprs_pkg;

    localparam int COORD_BITS   = 18;
    localparam int MAX_RUN_BITS = 12;

    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ROOT_W     = DIFF_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_W + 1);

    localparam int SPLIT_W = 36;
    localparam int MAXP_W  = 12;
    localparam int SRAD_W  = 18;
    localparam int SEQ_W   = 16;

    localparam int CMP_W     = (SQ_W > SPLIT_W) ? SQ_W : SPLIT_W;
    localparam int RUN_CMP_W = (MAX_RUN_BITS > MAXP_W) ? MAX_RUN_BITS : MAXP_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SPLIT_W;

    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_DIST_SQ = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SINGLE_RADIUS = CFG_IDX_W'(2);

    localparam logic [SPLIT_W-1:0] SPLIT_RESET = SPLIT_W'(10000);
    localparam logic [MAXP_W-1:0]  MAXP_RESET  = MAXP_W'(32);
    localparam logic [SRAD_W-1:0]  SRAD_RESET  = SRAD_W'(100);

    localparam logic [MAX_RUN_BITS-1:0] RUN_MAX = {MAX_RUN_BITS{1'b1}};
    localparam logic [SEQ_W-1:0]        SEQ_MAX = {SEQ_W{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP_X,
        ST_GAP_Y,
        ST_DECIDE,
        ST_SPAN_X,
        ST_SPAN_Y,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_EMIT
    } t_state;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic fresh;
        logic split;
        logic single;
        logic root_busy;
        logic out_free;
    } t_stat;

    // controls from the sequencer to the datapath
    typedef struct packed {
        logic take;
        logic mac_en;
        logic mac_first;
        logic mac_y;
        logic mac_span;
        logic root_start;
        logic open_run;
        logic seq_clear;
        logic extend_run;
        logic emit;
    } t_ctrl;

endpackage

### rtl/lprs_sqacc.sv
// lprs_sqacc: shared square-and-accumulate unit, one coordinate difference
// squared per cycle while enabled; depends on lprs_pkg
module lprs_sqacc (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic                                  i_first,
    input  logic signed [lprs_pkg::COORD_BITS-1:0] i_a,
    input  logic signed [lprs_pkg::COORD_BITS-1:0] i_b,
    output logic        [lprs_pkg::SQ_W-1:0]       o_acc
);

    logic signed [lprs_pkg::DIFF_W-1:0] diff;
    logic signed [lprs_pkg::SQ_W-1:0]   prod;
    logic        [lprs_pkg::SQ_W-1:0]   r_acc;

    assign diff = lprs_pkg::DIFF_W'(i_a) - lprs_pkg::DIFF_W'(i_b);
    assign prod = diff * diff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_first) begin
                r_acc <= $unsigned(prod);
            end else begin
                r_acc <= r_acc + $unsigned(prod);
            end
        end
    end

    assign o_acc = r_acc;

endmodule

### rtl/lprs_isqrt.sv
// lprs_isqrt: floor integer square root, one result bit per cycle
// (restoring digit recurrence); depends on lprs_pkg
module lprs_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lprs_pkg::SQ_W-1:0]     i_radicand,
    output logic                          o_busy,
    output logic [lprs_pkg::ROOT_W-1:0]   o_root
);

    logic [lprs_pkg::SQ_W-1:0]       r_rad;
    logic [lprs_pkg::REM_W-1:0]      r_rem;
    logic [lprs_pkg::ROOT_W-1:0]     r_root;
    logic [lprs_pkg::ROOT_CNT_W-1:0] r_cnt;
    logic                            r_busy;

    logic [lprs_pkg::REM_W-1:0] rem_sh;
    logic [lprs_pkg::REM_W-1:0] trial;
    logic                       fits;

    assign rem_sh = {r_rem[lprs_pkg::REM_W-3:0], r_rad[lprs_pkg::SQ_W-1 -: 2]};
    assign trial  = {r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= lprs_pkg::ROOT_CNT_W'(lprs_pkg::ROOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == lprs_pkg::ROOT_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[lprs_pkg::SQ_W-3:0], 2'b00};
            if (fits) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[lprs_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[lprs_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

### rtl/lprs_ctrl.sv
// lprs_ctrl: sequencer that steps one point through gap check,
// span measurement, square root and result emit; depends on lprs_pkg
module lprs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lprs_pkg::t_stat   i_stat,
    output lprs_pkg::t_ctrl   o_ctrl,
    output lprs_pkg::t_state  o_state
);

    lprs_pkg::t_state r_state;
    lprs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lprs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lprs_pkg::ST_IDLE: begin
                if (i_stat.in_valid) begin
                    n_state = lprs_pkg::ST_GAP_X;
                end
            end
            lprs_pkg::ST_GAP_X:  n_state = lprs_pkg::ST_GAP_Y;
            lprs_pkg::ST_GAP_Y:  n_state = lprs_pkg::ST_DECIDE;
            lprs_pkg::ST_DECIDE: begin
                if (i_stat.fresh || !i_stat.split) begin
                    n_state = lprs_pkg::ST_IDLE;
                end else if (i_stat.single) begin
                    n_state = lprs_pkg::ST_EMIT;
                end else begin
                    n_state = lprs_pkg::ST_SPAN_X;
                end
            end
            lprs_pkg::ST_SPAN_X:    n_state = lprs_pkg::ST_SPAN_Y;
            lprs_pkg::ST_SPAN_Y:    n_state = lprs_pkg::ST_ROOT_LOAD;
            lprs_pkg::ST_ROOT_LOAD: n_state = lprs_pkg::ST_ROOT;
            lprs_pkg::ST_ROOT: begin
                if (!i_stat.root_busy) begin
                    n_state = lprs_pkg::ST_EMIT;
                end
            end
            lprs_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    n_state = lprs_pkg::ST_IDLE;
                end
            end
            default: n_state = lprs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            lprs_pkg::ST_IDLE: o_ctrl.take = 1'b1;
            lprs_pkg::ST_GAP_X: begin
                o_ctrl.mac_en    = 1'b1;
                o_ctrl.mac_first = 1'b1;
            end
            lprs_pkg::ST_GAP_Y: begin
                o_ctrl.mac_en = 1'b1;
                o_ctrl.mac_y  = 1'b1;
            end
            lprs_pkg::ST_DECIDE: begin
                if (i_stat.fresh) begin
                    o_ctrl.open_run  = 1'b1;
                    o_ctrl.seq_clear = 1'b1;
                end else if (!i_stat.split) begin
                    o_ctrl.extend_run = 1'b1;
                end
            end
            lprs_pkg::ST_SPAN_X: begin
                o_ctrl.mac_en    = 1'b1;
                o_ctrl.mac_first = 1'b1;
                o_ctrl.mac_span  = 1'b1;
            end
            lprs_pkg::ST_SPAN_Y: begin
                o_ctrl.mac_en   = 1'b1;
                o_ctrl.mac_y    = 1'b1;
                o_ctrl.mac_span = 1'b1;
            end
            lprs_pkg::ST_ROOT_LOAD: o_ctrl.root_start = 1'b1;
            lprs_pkg::ST_ROOT: ;
            lprs_pkg::ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_ctrl.emit     = 1'b1;
                    o_ctrl.open_run = 1'b1;
                end
            end
            default: o_ctrl = '0;
        endcase
    end

    assign o_state = r_state;

endmodule

### rtl/lidar_point_run_segmenter.sv
// lidar_point_run_segmenter: breaks an ordered lidar point stream into runs
// and reports one obstacle per closed run. A point that extends or opens a run
// passes the gap check and the decision before ready again; a point that closes
// a run of two or more points also measures the span and runs the bit-serial
// square root, plus any wait for the output register; a one-point run skips both.
// Synchronous active-low reset clears the run, sequence count, config registers and output valid.
module lidar_point_run_segmenter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [lprs_pkg::COORD_BITS-1:0] i_x_pos,
    input  logic signed [lprs_pkg::COORD_BITS-1:0] i_y_pos,
    input  logic                                   i_frame_start,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic        [lprs_pkg::SEQ_W-1:0]      o_obstacle_seq,
    output logic signed [lprs_pkg::COORD_BITS-1:0] o_center_x,
    output logic signed [lprs_pkg::COORD_BITS-1:0] o_center_y,
    output logic        [lprs_pkg::ROOT_W-1:0]     o_radius,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic        [lprs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [lprs_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lprs_pkg::t_stat  stat;
    lprs_pkg::t_ctrl  ctrl;
    lprs_pkg::t_state state;

    logic [lprs_pkg::SPLIT_W-1:0] r_split_dist_sq;
    logic [lprs_pkg::MAXP_W-1:0]  r_max_points;
    logic [lprs_pkg::SRAD_W-1:0]  r_single_radius;

    logic signed [lprs_pkg::COORD_BITS-1:0] r_cur_x, r_cur_y;
    logic                                   r_frame;
    logic signed [lprs_pkg::COORD_BITS-1:0] r_start_x, r_start_y;
    logic signed [lprs_pkg::COORD_BITS-1:0] r_last_x, r_last_y;
    logic [lprs_pkg::MAX_RUN_BITS-1:0]      r_run_len;
    logic [lprs_pkg::SEQ_W-1:0]             r_seq;
    logic [lprs_pkg::SEQ_W-1:0]             n_seq;

    logic                                   r_out_valid;
    logic [lprs_pkg::SEQ_W-1:0]             r_out_seq;
    logic signed [lprs_pkg::COORD_BITS-1:0] r_out_cx, r_out_cy;
    logic [lprs_pkg::ROOT_W-1:0]            r_out_radius;

    logic signed [lprs_pkg::COORD_BITS-1:0] mac_a, mac_b;
    logic [lprs_pkg::SQ_W-1:0]              acc;
    logic                                   root_busy;
    logic [lprs_pkg::ROOT_W-1:0]            root;
    logic signed [lprs_pkg::DIFF_W-1:0]     sum_x, sum_y;
    logic                                   accept;

    assign accept      = ctrl.take && i_in_valid;
    assign o_in_stall  = !ctrl.take;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_dist_sq <= lprs_pkg::SPLIT_RESET;
            r_max_points    <= lprs_pkg::MAXP_RESET;
            r_single_radius <= lprs_pkg::SRAD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lprs_pkg::CFG_SPLIT_DIST_SQ:
                    r_split_dist_sq <= i_cfg_data[lprs_pkg::SPLIT_W-1:0];
                lprs_pkg::CFG_MAX_POINTS:
                    r_max_points <= i_cfg_data[lprs_pkg::MAXP_W-1:0];
                lprs_pkg::CFG_SINGLE_RADIUS:
                    r_single_radius <= i_cfg_data[lprs_pkg::SRAD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cur_x <= i_x_pos;
            r_cur_y <= i_y_pos;
            r_frame <= i_frame_start;
        end
    end

    // gap check pairs current with last; span pairs start with last
    assign mac_a = ctrl.mac_span ? (ctrl.mac_y ? r_start_y : r_start_x)
                                 : (ctrl.mac_y ? r_cur_y : r_cur_x);
    assign mac_b = ctrl.mac_y ? r_last_y : r_last_x;

    lprs_sqacc u_sqacc (
        .i_clk   (i_clk),
        .i_en    (ctrl.mac_en),
        .i_first (ctrl.mac_first),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    lprs_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (ctrl.root_start),
        .i_radicand (acc),
        .o_busy     (root_busy),
        .o_root     (root)
    );

    assign stat.in_valid  = i_in_valid;
    assign stat.fresh     = r_frame || (r_run_len == '0);
    assign stat.split     = (lprs_pkg::CMP_W'(acc) > lprs_pkg::CMP_W'(r_split_dist_sq))
                         || (lprs_pkg::RUN_CMP_W'(r_run_len)
                             >= lprs_pkg::RUN_CMP_W'(r_max_points));
    assign stat.single    = (r_run_len == lprs_pkg::MAX_RUN_BITS'(1));
    assign stat.root_busy = root_busy;
    assign stat.out_free  = !r_out_valid || !i_out_stall;

    lprs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl),
        .o_state (state)
    );

    always_comb begin
        n_seq = r_seq;
        if (ctrl.seq_clear) begin
            n_seq = '0;
        end else if (ctrl.emit && (r_seq != lprs_pkg::SEQ_MAX)) begin
            n_seq = r_seq + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_last_x  <= '0;
            r_last_y  <= '0;
            r_run_len <= '0;
            r_seq     <= '0;
        end else begin
            r_seq <= n_seq;
            if (ctrl.open_run) begin
                r_start_x <= r_cur_x;
                r_start_y <= r_cur_y;
                r_last_x  <= r_cur_x;
                r_last_y  <= r_cur_y;
                r_run_len <= lprs_pkg::MAX_RUN_BITS'(1);
            end else if (ctrl.extend_run) begin
                r_last_x <= r_cur_x;
                r_last_y <= r_cur_y;
                if (r_run_len != lprs_pkg::RUN_MAX) begin
                    r_run_len <= r_run_len + 1'b1;
                end
            end
        end
    end

    // floor of the half sum is an arithmetic shift of the widened sum
    assign sum_x = lprs_pkg::DIFF_W'(r_start_x) + lprs_pkg::DIFF_W'(r_last_x);
    assign sum_y = lprs_pkg::DIFF_W'(r_start_y) + lprs_pkg::DIFF_W'(r_last_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.emit) begin
            r_out_seq <= n_seq;
            r_out_cx  <= sum_x[lprs_pkg::COORD_BITS:1];
            r_out_cy  <= sum_y[lprs_pkg::COORD_BITS:1];
            if (stat.single) begin
                r_out_radius <= lprs_pkg::ROOT_W'(r_single_radius);
            end else begin
                r_out_radius <= root;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_obstacle_seq = r_out_seq;
    assign o_center_x     = r_out_cx;
    assign o_center_y     = r_out_cy;
    assign o_radius       = r_out_radius;

    // root unit is only started when idle
    a_root_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.root_start |-> !root_busy)
        else $error("square root started while busy");

    // a closed run always reopens with the current point alone
    a_emit_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |=> (r_run_len == lprs_pkg::MAX_RUN_BITS'(1)))
        else $error("run not reopened after obstacle");

    // obstacle numbers start at one
    a_seq_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_obstacle_seq != '0))
        else $error("obstacle sequence number is zero");

    // no result is emitted over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !ctrl.emit)
        else $error("pending obstacle overwritten");

    // the sequencer only takes a request when in its idle state
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.take |-> (state == lprs_pkg::ST_IDLE))
        else $error("request taken outside idle");

endmodule

### tb/lidar_point_run_segmenter_tb.sv
// lidar_point_run_segmenter_tb: self-checking bench for the lidar point run segmenter;
// a behavioral segmenter predicts each obstacle and every reported obstacle is compared
// with it. Depends on lprs_pkg and rtl/lidar_point_run_segmenter.sv with its submodules.
module lidar_point_run_segmenter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lprs_pkg::*;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RAND_POINTS  = 96;
    localparam int LONG_RUN_PTS = 60;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [SPLIT_W-1:0] SPLIT_FULL = {SPLIT_W{1'b1}};
    localparam logic [MAXP_W-1:0]  MAXP_FULL  = {MAXP_W{1'b1}};
    localparam logic [SRAD_W-1:0]  SRAD_FULL  = {SRAD_W{1'b1}};

    typedef struct {
        logic        [SEQ_W-1:0]      seq;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic        [ROOT_W-1:0]     radius;
    } t_obstacle;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_in_valid    = 1'b0;
    logic                           o_in_stall;
    logic signed [COORD_BITS-1:0]   i_x_pos       = '0;
    logic signed [COORD_BITS-1:0]   i_y_pos       = '0;
    logic                           i_frame_start = 1'b0;
    logic                           o_out_valid;
    logic                           i_out_stall   = 1'b0;
    logic        [SEQ_W-1:0]        o_obstacle_seq;
    logic signed [COORD_BITS-1:0]   o_center_x;
    logic signed [COORD_BITS-1:0]   o_center_y;
    logic        [ROOT_W-1:0]       o_radius;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic        [CFG_IDX_W-1:0]    i_cfg_index   = '0;
    logic        [CFG_DATA_W-1:0]   i_cfg_data    = '0;

    lidar_point_run_segmenter dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // behavioral copy of the segmenter state and registers
    logic        [SPLIT_W-1:0]      split_thresh;
    logic        [MAXP_W-1:0]       max_run_pts;
    logic        [SRAD_W-1:0]       lone_radius;
    logic signed [COORD_BITS-1:0]   run_first_x, run_first_y, run_last_x, run_last_y;
    logic        [MAX_RUN_BITS-1:0] run_len;
    logic        [SEQ_W-1:0]        obst_seq;

    t_obstacle pending_obstacles[$];
    t_obstacle head_obstacle;
    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    int        in_idle_pct    = 0;
    int        out_stall_pct  = 0;

    function automatic longint dist_sq(input logic signed [COORD_BITS-1:0] ax, ay, bx, by);
        longint dx;
        longint dy;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        return dx * dx + dy * dy;
    endfunction

    function automatic longint floor_sqrt(input longint n);
        longint root;
        longint trial;
        root = 0;
        for (int b = ROOT_W; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= n) root = trial;
        end
        return root;
    endfunction

    function automatic void reset_segmenter_model();
        split_thresh = SPLIT_RESET;
        max_run_pts  = MAXP_RESET;
        lone_radius  = SRAD_RESET;
        run_first_x  = '0;
        run_first_y  = '0;
        run_last_x   = '0;
        run_last_y   = '0;
        run_len      = '0;
        obst_seq     = '0;
    endfunction

    // advance the model by one point, queue the obstacle it closes if any
    function automatic void segment_point(input logic signed [COORD_BITS-1:0] px, py,
                                          input logic fs);
        t_obstacle ob;
        if (fs || run_len == '0) begin
            obst_seq = '0;
        end else if (dist_sq(px, py, run_last_x, run_last_y) > longint'(split_thresh) ||
                     run_len >= max_run_pts) begin
            if (obst_seq != SEQ_MAX) obst_seq = obst_seq + 1'b1;
            ob.seq = obst_seq;
            ob.cx  = COORD_BITS'((longint'(run_first_x) + longint'(run_last_x)) >>> 1);
            ob.cy  = COORD_BITS'((longint'(run_first_y) + longint'(run_last_y)) >>> 1);
            if (run_len == MAX_RUN_BITS'(1))
                ob.radius = ROOT_W'(lone_radius);
            else
                ob.radius = ROOT_W'(floor_sqrt(dist_sq(run_first_x, run_first_y,
                                                       run_last_x, run_last_y)));
            pending_obstacles = {pending_obstacles, ob};
        end else begin
            run_last_x = px;
            run_last_y = py;
            if (run_len != RUN_MAX) run_len = run_len + 1'b1;
            return;
        end
        run_first_x = px;
        run_first_y = py;
        run_last_x  = px;
        run_last_y  = py;
        run_len     = MAX_RUN_BITS'(1);
    endfunction

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] nudge(
            input logic signed [COORD_BITS-1:0] c, input longint d);
        longint v;
        v = longint'(c) + d;
        if (v > longint'(COORD_MAX)) v = longint'(COORD_MAX);
        if (v < longint'(COORD_MIN)) v = longint'(COORD_MIN);
        return COORD_BITS'(v);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] rand_coord();
        return COORD_BITS'($urandom);
    endfunction

    // result side: random stall and comparison against the oldest prediction
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_obstacles.size() == 0) begin
                flag_error($sformatf("unexpected obstacle seq=%0d cx=%0d cy=%0d r=%0d",
                                     o_obstacle_seq, o_center_x, o_center_y, o_radius));
            end else begin
                head_obstacle = pending_obstacles.pop_front();
                if (o_obstacle_seq !== head_obstacle.seq || o_center_x !== head_obstacle.cx ||
                    o_center_y !== head_obstacle.cy || o_radius !== head_obstacle.radius)
                    flag_error($sformatf(
                        "mismatch seq/cx/cy/r: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                        head_obstacle.seq, head_obstacle.cx, head_obstacle.cy,
                        head_obstacle.radius, o_obstacle_seq, o_center_x, o_center_y,
                        o_radius));
            end
        end
    end

    // watchdog: cycles without any request moving on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // valid stays high after the request so back-to-back points need no re-raise
    task automatic send_point(input logic signed [COORD_BITS-1:0] px, py, input logic fs);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_x_pos       <= px;
        i_y_pos       <= py;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        segment_point(px, py, fs);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_obstacles.size() != 0) @(posedge i_clk);
        // a point that closes nothing may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SPLIT_DIST_SQ: split_thresh = val[SPLIT_W-1:0];
            CFG_MAX_POINTS:    max_run_pts  = val[MAXP_W-1:0];
            CFG_SINGLE_RADIUS: lone_radius  = val[SRAD_W-1:0];
            default: ;
        endcase
    endtask

    // upper data bits are random and must be ignored; a stray index goes last
    task automatic write_config(input logic [SPLIT_W-1:0] split, input logic [MAXP_W-1:0] maxp,
                                input logic [SRAD_W-1:0] srad);
        logic [CFG_DATA_W-1:0] val;
        val = CFG_DATA_W'({$urandom, $urandom});
        val[SPLIT_W-1:0] = split;
        write_reg(CFG_SPLIT_DIST_SQ, val);
        val = CFG_DATA_W'({$urandom, $urandom});
        val[MAXP_W-1:0] = maxp;
        write_reg(CFG_MAX_POINTS, val);
        val = CFG_DATA_W'({$urandom, $urandom});
        val[SRAD_W-1:0] = srad;
        write_reg(CFG_SINGLE_RADIUS, val);
        write_reg(CFG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
        i_cfg_valid <= 1'b0;
    endtask

    // reset register values, no open run, splits by gap, extremes of coordinates
    task automatic test_defaults();
        send_point(0, 0, 1'b0);
        send_point(50, 50, 1'b0);
        send_point(100, 100, 1'b0);
        send_point(500, 0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MIN, COORD_MIN, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 1'b0);
        send_point(5, -5, 1'b1);
        send_point(-3, -3, 1'b0);
        send_point(-1000, 7, 1'b0);
        wait_drained();
    endtask

    // widest span, negative midpoint rounding, largest single-point radius
    task automatic test_extremes();
        write_config(SPLIT_FULL, 3, SRAD_FULL);
        send_point(COORD_MIN, COORD_MIN, 1'b1);
        send_point(0, 0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 1'b0);
        send_point(1, 1, 1'b0);
        send_point(2, 2, 1'b0);
        wait_drained();
        write_config('0, 1, SRAD_FULL);
        send_point(7, 7, 1'b0);
        send_point(7, 7, 1'b0);
        send_point(-7, 7, 1'b0);
        wait_drained();
    endtask

    // frame start drops the open run and every point without it closes one
    task automatic test_zero_max_points();
        write_config(SPLIT_FULL, '0, 42);
        send_point(1, 2, 1'b1);
        send_point(1, 2, 1'b0);
        send_point(3, 4, 1'b0);
        send_point(9, 9, 1'b1);
        send_point(9, 9, 1'b0);
        wait_drained();
    endtask

    // one long run that is forced to split at its point limit
    task automatic test_long_run();
        logic signed [COORD_BITS-1:0] px, py;
        write_config(SPLIT_FULL, MAXP_W'(LONG_RUN_PTS), SRAD_W'($urandom));
        px = 0;
        py = 0;
        send_point(px, py, 1'b1);
        for (int n = 0; n < LONG_RUN_PTS + 4; n++) begin
            px = nudge(px, longint'($urandom_range(40)) - 20);
            py = nudge(py, longint'($urandom_range(40)) - 20);
            send_point(px, py, 1'b0);
        end
        wait_drained();
    endtask

    // scans of clusters stepping near the split distance, with jumps and noise
    task automatic send_scans(input int count);
        logic signed [COORD_BITS-1:0] px, py;
        logic   fs;
        longint root;
        longint reach;
        int     pick;
        root = floor_sqrt(longint'(split_thresh));
        px = rand_coord();
        py = rand_coord();
        for (int n = 0; n < count; n++) begin
            fs   = (n == 0) || ($urandom_range(99) < 3);
            pick = $urandom_range(99);
            if (pick < 8) begin
                px = rand_coord();
                py = rand_coord();
                fs = ($urandom_range(7) == 0);
            end else if (pick < 25) begin
                px = rand_coord();
                py = rand_coord();
            end else begin
                reach = ($urandom_range(9) < 7) ? root / 2 : root + 1;
                px = nudge(px, longint'($urandom_range(32'(2 * reach))) - reach);
                py = nudge(py, longint'($urandom_range(32'(2 * reach))) - reach);
            end
            send_point(px, py, fs);
        end
    endtask

    task automatic test_random();
        logic [SPLIT_W-1:0] split;
        logic [MAXP_W-1:0]  maxp;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1:       begin in_idle_pct = 84; out_stall_pct = 0;  end
                2:       begin in_idle_pct = 0;  out_stall_pct = 84; end
                default: begin in_idle_pct = 16; out_stall_pct = 16; end
            endcase
            for (int sub = 0; sub < 2; sub++) begin
                wait_drained();
                if (phase == 0 && sub == 0) begin
                    write_config('0, 1, '0);
                end else if (phase == 1 && sub == 0) begin
                    write_config(SPLIT_FULL, MAXP_FULL, SRAD_FULL);
                end else begin
                    split = ($urandom_range(3) == 0) ? SPLIT_W'({$urandom, $urandom})
                                                     : SPLIT_W'($urandom_range(1 << 22));
                    maxp  = ($urandom_range(4) == 0) ? MAXP_W'($urandom)
                                                     : MAXP_W'($urandom_range(16, 1));
                    write_config(split, maxp, SRAD_W'($urandom));
                end
                send_scans(RAND_POINTS);
            end
        end
        wait_drained();
        in_idle_pct   = 0;
        out_stall_pct = 0;
    endtask

    initial begin
        reset_segmenter_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_extremes();
        test_zero_max_points();
        test_long_run();
        test_random();
        if (pending_obstacles.size() != 0)
            flag_error($sformatf("%0d obstacles never reported", pending_obstacles.size()));
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
